>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, quiet while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/bdq_pkg.sv
package bdq_pkg;

  // Default geometry
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  // Capacity register value after reset
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  // Operation codes; 6 and 7 are no-ops
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } opcode_t;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

>>> rtl/core/bdq_ram.sv
// Ring store: one synchronous port, write or registered read per cycle.
module bdq_ram
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [IDX_W-1:0]      addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // rdata holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bounded_deque.sv
// Bounded double-ended queue kept in a ring store with front index and count.
// Each result passes the store access and pending stage, then the output register,
// which drives out_tvalid and holds the result while out_tready is low.
// Throughput: one request per cycle while out_tready is high; the single
// store port serves each request's one write or one read in its accept cycle.
// Reset (synchronous, active low): queue empty, front index 0, capacity 16;
// store contents are not cleared.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // request channel
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // in_tdata: push_value, zero padded to bytes
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]           in_tdata,
  // in_tuser: opcode
  input  logic [OPCODE_W-1:0]                       in_tuser,
  // result channel
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // out_tdata: read_value, occupancy, is_empty, is_full, zero padded to bytes
  output logic [((DATA_WIDTH+$clog2(DEPTH+1)+2+7)/8)*8-1:0] out_tdata,
  // out_tuser: status
  output logic [STATUS_W-1:0]                       out_tuser,
  // capacity register write
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_W-1:0]                          cfg_data
);

  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 2 + 7) / 8) * 8;

  // ---------------------------------------------------------------------
  // Capacity register
  logic [CFG_W-1:0] max_entries_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_entries_r <= cfg_data;
    end
  end

  // effective capacity saturates at DEPTH
  logic [CMP_W-1:0] cap;
  always_comb begin
    if (CMP_W'(max_entries_r) > CMP_W'(DEPTH)) begin
      cap = CMP_W'(DEPTH);
    end else begin
      cap = CMP_W'(max_entries_r);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake between request, pending and output stages
  logic p_valid_r, p_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic p_move, in_acc;

  assign p_move    = p_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p_valid_r || p_move;
  assign in_acc    = in_tvalid && in_tready;

  assign p_valid_nxt   = in_acc || (p_valid_r && !p_move);
  assign out_valid_nxt = p_move || (out_valid_r && !out_tready);

  // ---------------------------------------------------------------------
  // Queue pointers and operation decode
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  opcode_t          op;
  logic             q_full, q_empty;
  logic [SUM_W-1:0] back_sum, last_sum;
  logic [IDX_W-1:0] back_idx, last_idx, front_dec, front_inc;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_addr;
  status_t          req_status;

  assign op      = opcode_t'(in_tuser);
  assign q_full  = CMP_W'(count_r) >= cap;
  assign q_empty = (count_r == '0);

  // ring positions: slot after the back, last word, neighbors of the front
  always_comb begin
    back_sum = SUM_W'(front_r) + SUM_W'(count_r);
    last_sum = back_sum - SUM_W'(1);
    if (back_sum >= SUM_W'(DEPTH)) begin
      back_idx = IDX_W'(back_sum - SUM_W'(DEPTH));
    end else begin
      back_idx = IDX_W'(back_sum);
    end
    if (last_sum >= SUM_W'(DEPTH)) begin
      last_idx = IDX_W'(last_sum - SUM_W'(DEPTH));
    end else begin
      last_idx = IDX_W'(last_sum);
    end
    if (front_r == '0) begin
      front_dec = IDX_W'(DEPTH - 1);
    end else begin
      front_dec = front_r - IDX_W'(1);
    end
    if (front_r == IDX_W'(DEPTH - 1)) begin
      front_inc = '0;
    end else begin
      front_inc = front_r + IDX_W'(1);
    end
  end

  // per-request store access and pointer update
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = front_r;
    req_status = ST_OK;
    if (in_acc) begin
      unique case (op)
        OP_PUSH_FRONT: begin
          if (q_full) begin
            req_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (q_full) begin
            req_status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = back_idx;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (q_empty) begin
            req_status = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            ram_addr = front_r;
            if (op == OP_POP_FRONT) begin
              front_nxt = front_inc;
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (q_empty) begin
            req_status = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            ram_addr = last_idx;
            if (op == OP_POP_BACK) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
        default: begin
          // unused codes leave the queue as it is
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Store
  logic [DATA_WIDTH-1:0] ram_rdata;

  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_tdata[DATA_WIDTH-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pending stage: status and post-operation counts wait for the read data
  status_t          p_status_r;
  logic             p_rd_r;
  logic [CNT_W-1:0] p_count_r;
  logic             p_empty_r, p_full_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_status_r <= req_status;
      p_rd_r     <= ram_re;
      p_count_r  <= count_nxt;
      p_empty_r  <= (count_nxt == '0);
      p_full_r   <= (CMP_W'(count_nxt) >= cap);
    end
  end

  // Output register
  status_t               o_status_r;
  logic [DATA_WIDTH-1:0] o_value_r;
  logic [CNT_W-1:0]      o_count_r;
  logic                  o_empty_r, o_full_r;

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_status_r <= p_status_r;
      o_value_r  <= p_rd_r ? ram_rdata : '0;
      o_count_r  <= p_count_r;
      o_empty_r  <= p_empty_r;
      o_full_r   <= p_full_r;
    end
  end

  // Result packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;

  always_comb begin
    out_tdata                             = '0;
    out_tdata[DATA_WIDTH-1:0]             = o_value_r;
    out_tdata[DATA_WIDTH +: CNT_W]        = o_count_r;
    out_tdata[DATA_WIDTH + CNT_W]         = o_empty_r;
    out_tdata[DATA_WIDTH + CNT_W + 1]     = o_full_r;
  end

endmodule

>>> rtl/core/bdq_checker.sv
// Port-level checks for the deque.
`include "assert_macros.svh"

module bdq_checker
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int CNT_W       = 5,
  parameter int OUT_TDATA_W = 40
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  logic             r_empty, r_full, stall;
  logic [CNT_W-1:0] r_count;

  assign r_count = out_tdata[DATA_WIDTH +: CNT_W];
  assign r_empty = out_tdata[DATA_WIDTH + CNT_W];
  assign r_full  = out_tdata[DATA_WIDTH + CNT_W + 1];
  assign stall   = out_tvalid && !out_tready;

  // a waiting result is neither dropped nor altered
  `ASSERT_NEXT(a_hold_valid, clk, rst_n, stall, out_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst_n, stall, $stable(out_tdata) && $stable(out_tuser))

  // empty flag tracks the reported count
  `ASSERT_IMPLY(a_empty_flag, clk, rst_n, out_tvalid, r_empty == (r_count == '0))

  // a refused read returns zero on an empty queue
  `ASSERT_IMPLY(a_empty_refusal, clk, rst_n, out_tvalid && (out_tuser == ST_EMPTY),
                r_empty && (out_tdata[DATA_WIDTH-1:0] == '0))

  // a refused push reports a full queue
  `ASSERT_IMPLY(a_full_refusal, clk, rst_n, out_tvalid && (out_tuser == ST_FULL), r_full)

endmodule

bind bounded_deque bdq_checker #(
  .DATA_WIDTH  (DATA_WIDTH),
  .CNT_W       (CNT_W),
  .OUT_TDATA_W (OUT_TDATA_W)
) u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/deque_tb_pkg.sv
`timescale 1ns / 1ps
package deque_tb_pkg;
  import bdq_pkg::*;

  // Port geometry at the default parameters
  localparam int IDX_W = $clog2(DEPTH_DEF);
  localparam int OCC_W = $clog2(DEPTH_DEF + 1);
  localparam int IN_W  = ((DATA_WIDTH_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((DATA_WIDTH_DEF + OCC_W + 2 + 7) / 8) * 8;

  // Opcodes outside the enum; the block answers them without touching state
  localparam logic [OPCODE_W-1:0] OP_NOP_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_NOP_7 = 3'd7;

  typedef struct {
    logic [DATA_WIDTH_DEF-1:0] read_value;
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      is_full;
  } deque_reply_t;

  class deque_scoreboard;
    // Shadow copy of the ring store, front index, count and capacity register
    logic [DATA_WIDTH_DEF-1:0] words [DEPTH_DEF];
    logic [IDX_W-1:0]          head;
    logic [OCC_W-1:0]          fill;
    logic [CFG_W-1:0]          capacity;
    deque_reply_t              expected_replies [$];
    int replies_checked;
    int mismatches;
    int full_refusals;
    int empty_refusals;

    function new();
      head            = '0;
      fill            = '0;
      capacity        = MAX_ENTRIES_RST;
      replies_checked = 0;
      mismatches      = 0;
      full_refusals   = 0;
      empty_refusals  = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Apply one accepted request to the shadow deque and queue its reply
    function void note_request(logic [OPCODE_W-1:0] op, logic [DATA_WIDTH_DEF-1:0] value);
      deque_reply_t     r;
      logic [OCC_W-1:0] limit;
      logic [IDX_W-1:0] slot;
      logic             at_limit;
      // capacity saturates at the store depth
      limit      = (capacity > DEPTH_DEF) ? OCC_W'(DEPTH_DEF) : OCC_W'(capacity);
      at_limit   = (fill >= limit);
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (at_limit) begin
            r.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head = head - 1'b1;
              slot = head;
            end else begin
              slot = head + fill[IDX_W-1:0];
            end
            words[slot] = value;
            fill        = fill + 1'b1;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) slot = head;
            else slot = head + fill[IDX_W-1:0] - 1'b1;
            r.read_value = words[slot];
            if (op == OP_POP_FRONT) head = head + 1'b1;
            if (op == OP_POP_FRONT || op == OP_POP_BACK) fill = fill - 1'b1;
          end
        end
        default: ;
      endcase
      r.occupancy = fill;
      r.is_empty  = (fill == 0);
      r.is_full   = (fill >= limit);
      if (r.status == ST_FULL) full_refusals++;
      if (r.status == ST_EMPTY) empty_refusals++;
      expected_replies.push_back(r);
    endfunction

    // Compare one accepted reply with the oldest outstanding prediction
    function void check_reply(logic [OUT_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
      deque_reply_t              exp_r;
      logic [DATA_WIDTH_DEF-1:0] got_value;
      logic [OCC_W-1:0]          got_fill;
      logic                      got_empty;
      logic                      got_full;
      got_value = tdata[DATA_WIDTH_DEF-1:0];
      got_fill  = tdata[DATA_WIDTH_DEF +: OCC_W];
      got_empty = tdata[DATA_WIDTH_DEF + OCC_W];
      got_full  = tdata[DATA_WIDTH_DEF + OCC_W + 1];
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply without request: value %h status %0d count %0d empty %b full %b",
                   got_value, tuser, got_fill, got_empty, got_full);
        return;
      end
      exp_r = expected_replies.pop_front();
      replies_checked++;
      if (got_value !== exp_r.read_value || tuser !== exp_r.status ||
          got_fill !== exp_r.occupancy || got_empty !== exp_r.is_empty ||
          got_full !== exp_r.is_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reply %0d mismatch: expected value %h status %0d count %0d empty %b full %b",
                   replies_checked, exp_r.read_value, exp_r.status, exp_r.occupancy,
                   exp_r.is_empty, exp_r.is_full);
          $display("                    got      value %h status %0d count %0d empty %b full %b",
                   got_value, tuser, got_fill, got_empty, got_full);
        end
      end
    endfunction
  endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bdq_pkg::*;
  import deque_tb_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;

  // request mix used by the random part
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;
  logic [OPCODE_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_W-1:0]       out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  deque_scoreboard sb = new();

  int rx_hold_request = 0;
  bit rx_gappy        = 1'b0;
  int requests_sent   = 0;
  int settings_used   = 0;

  bounded_deque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: check accepted replies, stall at random or on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser);
      if (rx_hold_request > 0) begin
        stall_left      = rx_hold_request;
        rx_hold_request = 0;
      end else if (stall_left == 0 && rx_gappy && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays high afterwards
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [DATA_WIDTH_DEF-1:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'(value);
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value);
    requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted reply came back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sb.capacity = cap;
    settings_used++;
  endtask

  initial begin
    logic [OPCODE_W-1:0]       op;
    logic [DATA_WIDTH_DEF-1:0] value;
    logic [CFG_W-1:0]          cap_setting;
    mix_t                      mix;
    int                        mix_left;
    int                        push_pct;
    int                        done_in_phase;
    int                        pick;
    bit                        tx_gappy;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PUSH_FRONT;
    cfg_valid <= 1'b0;
    cfg_data  <= MAX_ENTRIES_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty refusals, no-ops, extreme words at both ends, front wrap
    send_request(OP_POP_FRONT, 32'h1234_5678);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_PEEK_FRONT, 32'hffff_ffff);
    send_request(OP_PEEK_BACK, 32'h8000_0000);
    send_request(OP_NOP_6, 32'hffff_ffff);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h0);
    send_request(OP_PUSH_BACK, 32'hffff_ffff);
    send_request(OP_PEEK_FRONT, 32'h0);
    send_request(OP_PEEK_BACK, 32'h0);
    send_request(OP_NOP_7, 32'h5555_5555);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_FRONT, 32'h0);
    // zero capacity below the count: pushes refused, pops still drain
    write_capacity(5'd0);
    send_request(OP_PUSH_BACK, 32'ha5a5_a5a5);
    send_request(OP_POP_FRONT, 32'h0);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_PUSH_FRONT, 32'h1);
    send_request(OP_PEEK_BACK, 32'h0);
    // single-entry capacity
    write_capacity(5'd1);
    send_request(OP_PUSH_BACK, 32'h5a5a_5a5a);
    send_request(OP_PUSH_FRONT, 32'h2);
    send_request(OP_POP_FRONT, 32'h0);

    // Random phases, each with its own capacity and idling pattern
    mix      = MIX_FILL;
    mix_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       cap_setting = 5'd31;
        1:       cap_setting = 5'd16;
        2:       cap_setting = 5'd2;
        3:       cap_setting = 5'd1;
        4:       cap_setting = 5'd0;
        5:       cap_setting = 5'd17;
        6:       cap_setting = 5'd15;
        default: cap_setting = CFG_W'($urandom_range(1, 16));
      endcase
      write_capacity(cap_setting);
      tx_gappy = (phase % 3 != 1);
      rx_gappy = (phase % 4 != 2);
      // long receiver hold-off while the sender keeps pushing
      if (phase == 1) begin
        mix             = MIX_FILL;
        mix_left        = 40;
        rx_hold_request = 80;
      end
      done_in_phase = 0;
      while (done_in_phase < PHASE_ITEMS) begin
        if (mix_left == 0) begin
          mix      = mix_t'($urandom_range(0, 2));
          mix_left = $urandom_range(10, 40);
        end
        push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
        pick     = $urandom_range(0, 99);
        if (pick < 3) begin
          op = (pick == 0) ? OP_NOP_6 : OP_NOP_7;
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          case ($urandom_range(0, 5))
            0, 1:    op = OP_POP_FRONT;
            2, 3:    op = OP_POP_BACK;
            4:       op = OP_PEEK_FRONT;
            default: op = OP_PEEK_BACK;
          endcase
        end
        case ($urandom_range(0, 15))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7fff_ffff;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom();
        endcase
        send_request(op, value);
        if (op != OP_NOP_6 && op != OP_NOP_7) begin
          done_in_phase++;
          mix_left--;
        end
        if (tx_gappy && $urandom_range(0, 3) == 0) pause_sender(pick_gap());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("ran %0d requests over %0d capacity settings (%0d refused full, %0d refused empty)",
             requests_sent, settings_used, sb.full_refusals, sb.empty_refusals);
    $display("checked %0d replies, %0d mismatches", sb.replies_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
